@@ src/gcs_pkg.sv @@
`timescale 1ns / 1ps

package gcs_pkg;

    // Width of the sample counter and the phase remainder.
    localparam int COUNT_WIDTH = 16;

    // Width used to clamp the configured period before it is narrowed.
    localparam int CLAMP_WIDTH = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

    localparam int PRN_WIDTH    = 6;
    localparam int PERIOD_WIDTH = 16;
    localparam int CHIP_WIDTH   = 10;
    localparam int LFSR_WIDTH   = 10;

    localparam logic [CHIP_WIDTH-1:0]  CODE_CHIPS = 10'd1023;
    localparam logic [LFSR_WIDTH-1:0]  LFSR_ONES  = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;

    localparam logic [PRN_WIDTH-1:0] PRN_MIN = 6'd1;
    localparam logic [PRN_WIDTH-1:0] PRN_MAX = 6'd37;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd4000;

    // Configuration register indexes.
    localparam logic REG_PRN    = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    // Stage numbers 1..10 of one G2 phase-select tap.
    typedef logic [3:0] tap_t;

    typedef struct packed {
        tap_t first;
        tap_t second;
    } tap_pair_t;

    // One emitted sample.
    typedef struct packed {
        logic                  last_in_period;
        logic [CHIP_WIDTH-1:0] chip_index;
        logic                  chip_level;
    } sample_t;

    // G2 phase-select tap pair for PRN 1..37; other codes are clamped first.
    function automatic tap_pair_t prn_taps(input logic [PRN_WIDTH-1:0] prn);
        tap_pair_t t;
        case (prn)
            6'd1:    t = '{4'd2, 4'd6};
            6'd2:    t = '{4'd3, 4'd7};
            6'd3:    t = '{4'd4, 4'd8};
            6'd4:    t = '{4'd5, 4'd9};
            6'd5:    t = '{4'd1, 4'd9};
            6'd6:    t = '{4'd2, 4'd10};
            6'd7:    t = '{4'd1, 4'd8};
            6'd8:    t = '{4'd2, 4'd9};
            6'd9:    t = '{4'd3, 4'd10};
            6'd10:   t = '{4'd2, 4'd3};
            6'd11:   t = '{4'd3, 4'd4};
            6'd12:   t = '{4'd5, 4'd6};
            6'd13:   t = '{4'd6, 4'd7};
            6'd14:   t = '{4'd7, 4'd8};
            6'd15:   t = '{4'd8, 4'd9};
            6'd16:   t = '{4'd9, 4'd10};
            6'd17:   t = '{4'd1, 4'd4};
            6'd18:   t = '{4'd2, 4'd5};
            6'd19:   t = '{4'd3, 4'd6};
            6'd20:   t = '{4'd4, 4'd7};
            6'd21:   t = '{4'd5, 4'd8};
            6'd22:   t = '{4'd6, 4'd9};
            6'd23:   t = '{4'd1, 4'd3};
            6'd24:   t = '{4'd4, 4'd6};
            6'd25:   t = '{4'd5, 4'd7};
            6'd26:   t = '{4'd6, 4'd8};
            6'd27:   t = '{4'd7, 4'd9};
            6'd28:   t = '{4'd8, 4'd10};
            6'd29:   t = '{4'd1, 4'd6};
            6'd30:   t = '{4'd2, 4'd7};
            6'd31:   t = '{4'd3, 4'd8};
            6'd32:   t = '{4'd4, 4'd9};
            6'd33:   t = '{4'd5, 4'd10};
            6'd34:   t = '{4'd4, 4'd10};
            6'd35:   t = '{4'd1, 4'd7};
            6'd36:   t = '{4'd2, 4'd8};
            6'd37:   t = '{4'd4, 4'd10};
            default: t = '{4'd2, 4'd6};
        endcase
        return t;
    endfunction

    // Pick stage n (1..10) of a 10-bit shift register.
    function automatic logic lfsr_stage(input logic [LFSR_WIDTH-1:0] r, input tap_t n);
        logic [3:0] idx;
        idx = n - 4'd1;
        return (idx < 4'(LFSR_WIDTH)) ? r[idx] : 1'b0;
    endfunction

endpackage

@@ src/gcs_core.sv @@
`timescale 1ns / 1ps

module gcs_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          restart,
    input  logic [gcs_pkg::PRN_WIDTH-1:0]    satellite_prn,
    input  logic [gcs_pkg::PERIOD_WIDTH-1:0] period_len,
    output gcs_pkg::sample_t              sample
);
    import gcs_pkg::*;

    logic [LFSR_WIDTH-1:0]  g1_reg, g1_next;
    logic [LFSR_WIDTH-1:0]  g2_reg, g2_next;
    logic [CHIP_WIDTH-1:0]  chip_reg, chip_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;

    logic [LFSR_WIDTH-1:0]  g1_cur, g2_cur;
    logic [CHIP_WIDTH-1:0]  chip_cur;
    logic [COUNT_WIDTH-1:0] count_cur, rem_cur;
    logic [PRN_WIDTH-1:0]   prn_eff;
    tap_pair_t              taps;
    logic [CLAMP_WIDTH-1:0] period_wide;
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH:0]   phase_sum;
    logic [CHIP_WIDTH-1:0]  chip_inc;
    logic                   last;
    logic                   advance;
    logic                   fb1, fb2;

    // Clamp the configuration to the supported ranges.
    always_comb
    begin
        if (satellite_prn < PRN_MIN)
            prn_eff = PRN_MIN;
        else if (satellite_prn > PRN_MAX)
            prn_eff = PRN_MAX;
        else
            prn_eff = satellite_prn;
        taps = prn_taps(prn_eff);

        period_wide = CLAMP_WIDTH'(period_len);
        if (period_wide < CLAMP_WIDTH'(CODE_CHIPS))
            period_wide = CLAMP_WIDTH'(CODE_CHIPS);
        else if (period_wide > CLAMP_WIDTH'(COUNT_MAX))
            period_wide = CLAMP_WIDTH'(COUNT_MAX);
        period = period_wide[COUNT_WIDTH-1:0];
    end

    // A restart word sees the state of a fresh period.
    always_comb
    begin
        g1_cur    = restart ? LFSR_ONES : g1_reg;
        g2_cur    = restart ? LFSR_ONES : g2_reg;
        chip_cur  = restart ? '0 : chip_reg;
        count_cur = restart ? '0 : count_reg;
        rem_cur   = restart ? '0 : rem_reg;
    end

    // Output chip and end-of-period flag.
    always_comb
    begin
        last = (count_cur >= period - COUNT_WIDTH'(1));
        sample.chip_level = g1_cur[LFSR_WIDTH-1]
                          ^ lfsr_stage(g2_cur, taps.first)
                          ^ lfsr_stage(g2_cur, taps.second);
        sample.chip_index = chip_cur;
        sample.last_in_period = last;
    end

    // Rational phase accumulator and LFSR update.
    always_comb
    begin
        phase_sum = {1'b0, rem_cur} + (COUNT_WIDTH+1)'(CODE_CHIPS);
        advance   = (phase_sum >= {1'b0, period});
        fb1 = g1_cur[2] ^ g1_cur[9];
        fb2 = g2_cur[1] ^ g2_cur[2] ^ g2_cur[5] ^ g2_cur[7] ^ g2_cur[8] ^ g2_cur[9];
        chip_inc = chip_cur + CHIP_WIDTH'(1);

        g1_next    = g1_cur;
        g2_next    = g2_cur;
        chip_next  = chip_cur;
        count_next = count_cur + COUNT_WIDTH'(1);
        rem_next   = phase_sum[COUNT_WIDTH-1:0];

        if (last)
        begin
            g1_next    = LFSR_ONES;
            g2_next    = LFSR_ONES;
            chip_next  = '0;
            count_next = '0;
            rem_next   = '0;
        end
        else if (advance)
        begin
            rem_next = COUNT_WIDTH'(phase_sum - {1'b0, period});
            if (chip_inc >= CODE_CHIPS)
            begin
                chip_next = '0;
                g1_next   = LFSR_ONES;
                g2_next   = LFSR_ONES;
            end
            else
            begin
                chip_next = chip_inc;
                g1_next   = {g1_cur[LFSR_WIDTH-2:0], fb1};
                g2_next   = {g2_cur[LFSR_WIDTH-2:0], fb2};
            end
        end
    end

    // Code state, updated once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg    <= LFSR_ONES;
            g2_reg    <= LFSR_ONES;
            chip_reg  <= '0;
            count_reg <= '0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            g1_reg    <= g1_next;
            g2_reg    <= g2_next;
            chip_reg  <= chip_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
        end
    end

    // The chip counter never reaches the code length.
    a_chip_range: assert property (@(posedge clk) disable iff (!rst_n)
        chip_reg < CODE_CHIPS)
        else $error("chip counter out of range");

    // The word after the period end starts a fresh period.
    a_period_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> count_reg == '0 && chip_reg == '0 && rem_reg == '0)
        else $error("period did not wrap");

    // Inside a period the sample counter counts every word.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last |=> count_reg == $past(count_cur) + COUNT_WIDTH'(1))
        else $error("sample counter skipped");

    // A restart word always reports chip zero.
    a_restart_chip: assert property (@(posedge clk) disable iff (!rst_n)
        step && restart |-> sample.chip_index == '0)
        else $error("restart did not start at chip zero");

endmodule

@@ src/gps_ca_code_sampler.sv @@
`timescale 1ns / 1ps

// GPS L1 C/A code sampler. Every word accepted on the slave stream produces
// one sample of the 1023-chip Gold code of the configured PRN, resampled so
// that one code period spans the configured number of words (values below
// 1023 run as 1023). One word is taken per clock while the master side keeps
// tready high: the code state updates once per accepted word and the result
// sits in one output register, so throughput is one sample per cycle. Bit 0
// of the input word restarts the period at chip 0 before that sample is
// produced. Register 0 is the PRN (1 to 37, others clamped), register 1 the
// period length; writes apply from the next word on.
module gps_ca_code_sampler (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // Slave stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // Master stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] chip_level, [10:1] chip_index, [15:11] zero
    output logic        m_tlast    // last_in_period
);
    import gcs_pkg::*;

    logic [PRN_WIDTH-1:0]    prn_reg;
    logic [PERIOD_WIDTH-1:0] period_reg;
    logic                    out_valid_reg;
    sample_t                 out_reg;
    sample_t                 sample;
    logic                    step;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prn_reg    <= PRN_MIN;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_PRN:    prn_reg    <= cfg_wdata[PRN_WIDTH-1:0];
                REG_PERIOD: period_reg <= cfg_wdata[PERIOD_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    // A new word is taken whenever the output register is empty or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    gcs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .restart       (s_tdata[0]),
        .satellite_prn (prn_reg),
        .period_len    (period_reg),
        .sample        (sample)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= sample;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.chip_index, out_reg.chip_level};
    assign m_tlast  = out_reg.last_in_period;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import gcs_pkg::*;

    localparam int CODE_LEN = 1023;
    localparam int CNT_MASK = (1 << COUNT_WIDTH) - 1;

    // G2 phase-select stages for PRN 1..37, first and second tap.
    localparam int TAP_A [37] = '{2, 3, 4, 5, 1, 2, 1, 2, 3, 2, 3, 5, 6, 7, 8, 9, 1, 2, 3,
                                  4, 5, 6, 1, 4, 5, 6, 7, 8, 1, 2, 3, 4, 5, 4, 1, 2, 4};
    localparam int TAP_B [37] = '{6, 7, 8, 9, 9, 10, 8, 9, 10, 3, 4, 6, 7, 8, 9, 10, 4, 5,
                                  6, 7, 8, 9, 3, 6, 7, 8, 9, 10, 6, 7, 8, 9, 10, 10, 7, 8,
                                  10};

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic        cfg_index = REG_PRN;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Predicted code generator state and its configuration copy.
    logic [9:0]  g1_shift;
    logic [9:0]  g2_shift;
    int          chip_count;
    int          sample_count;
    int          phase_rem;
    logic [5:0]  cfg_prn;
    logic [15:0] cfg_period;

    sample_t     expected_samples [$];

    int send_idle_pct = 24;
    int recv_idle_pct = 46;
    int hold_request  = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int words_sent    = 0;
    int samples_seen  = 0;
    int writes_done   = 0;

    gps_ca_code_sampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("[gps_ca_code_sampler] ERROR");
        $finish;
    end

    function automatic void restart_code();
        g1_shift     = '1;
        g2_shift     = '1;
        chip_count   = 0;
        sample_count = 0;
        phase_rem    = 0;
    endfunction

    // Emit one sample of the code and advance the predicted state.
    function automatic sample_t predict_sample(input bit restart);
        sample_t s;
        int      p;
        int      prn;
        int      r;
        logic    fb1;
        logic    fb2;
        p = cfg_period;
        if (p < CODE_LEN) p = CODE_LEN;
        if (p > CNT_MASK) p = CNT_MASK;
        if (restart) restart_code();
        prn = cfg_prn;
        if (prn < 1) prn = 1;
        if (prn > 37) prn = 37;
        s.chip_level     = g1_shift[9] ^ g2_shift[TAP_A[prn-1]-1] ^ g2_shift[TAP_B[prn-1]-1];
        s.chip_index     = chip_count[9:0];
        s.last_in_period = (sample_count >= p - 1);
        if (s.last_in_period)
        begin
            restart_code();
        end
        else
        begin
            r = phase_rem + CODE_LEN;
            sample_count = (sample_count + 1) & CNT_MASK;
            // A chip boundary was crossed: clock both shift registers once.
            if (r >= p)
            begin
                r -= p;
                fb1 = g1_shift[2] ^ g1_shift[9];
                fb2 = g2_shift[1] ^ g2_shift[2] ^ g2_shift[5] ^ g2_shift[7] ^ g2_shift[8]
                      ^ g2_shift[9];
                g1_shift = {g1_shift[8:0], fb1};
                g2_shift = {g2_shift[8:0], fb2};
                chip_count++;
                if (chip_count >= CODE_LEN)
                begin
                    chip_count = 0;
                    g1_shift   = '1;
                    g2_shift   = '1;
                end
            end
            phase_rem = r & CNT_MASK;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < 40) $display("%0t: mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Offer one word, with random idle cycles in front, and wait for the handshake.
    task automatic send_word(input bit restart);
        int      gap;
        sample_t want;
        gap = 0;
        @(negedge clk);
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge clk); while (!s_tready);
        want = predict_sample(restart);
        expected_samples = {expected_samples, want};
        words_sent++;
    endtask

    task automatic send_run(input int count);
        repeat (count) send_word(1'b0);
    endtask

    // Stop offering words and wait until every expected sample has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        if (idx == REG_PRN) cfg_prn = value[5:0];
        else cfg_period = value;
        writes_done++;
    endtask

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted sample with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        sample_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch("sample arrived with none expected");
            end
            else
            begin
                want = expected_samples.pop_front();
                samples_seen++;
                if (m_tdata[0] !== want.chip_level)
                    report_mismatch($sformatf("sample %0d chip_level %b, want %b",
                                              samples_seen, m_tdata[0], want.chip_level));
                if (m_tdata[10:1] !== want.chip_index)
                    report_mismatch($sformatf("sample %0d chip_index %0d, want %0d",
                                              samples_seen, m_tdata[10:1], want.chip_index));
                if (m_tlast !== want.last_in_period)
                    report_mismatch($sformatf("sample %0d last_in_period %b, want %b",
                                              samples_seen, m_tlast, want.last_in_period));
            end
        end
    end

    // Restarts, PRN codes at and beyond both ends, and extreme period values.
    task automatic test_directed_edges();
        logic [5:0] prn_corners [5];
        prn_corners = '{6'd0, 6'd63, 6'd38, 6'd37, 6'd1};
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        foreach (prn_corners[i])
        begin
            drain_results();
            write_register(REG_PRN, {10'h3FF, prn_corners[i]});
            send_word(1'b1);
            send_word(1'b0);
            send_word(1'b0);
        end
        drain_results();
        write_register(REG_PERIOD, 16'd0);
        send_run(2);
        drain_results();
        write_register(REG_PERIOD, 16'hFFFF);
        send_run(2);
        drain_results();
    endtask

    // Shorten the period while the remainder is well above the new length,
    // so it loses one period per word until it falls below it.
    task automatic test_remainder_over_period();
        write_register(REG_PERIOD, 16'd65535);
        send_word(1'b1);
        send_run(3);
        drain_results();
        write_register(REG_PERIOD, 16'd2000);
        send_run(6);
        drain_results();
    endtask

    // A period below 1023 samples runs as 1023, one chip per word. Stop one
    // word before its end and lengthen it so the chip counter wraps, then
    // shorten it to the sample count so the period closes on the next word.
    task automatic test_chip_wrap();
        write_register(REG_PRN, 16'($urandom_range(1, 37)));
        write_register(REG_PERIOD, 16'd1);
        send_word(1'b1);
        send_run(1021);
        drain_results();
        write_register(REG_PERIOD, 16'd2046);
        send_run(2);
        drain_results();
        write_register(REG_PERIOD, 16'd1024);
        send_run(3);
        drain_results();
    endtask

    // Long receiver hold-off while words keep coming, then a full pause.
    task automatic test_backpressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        @(posedge clk);
        hold_request = 60;
        send_run(30);
        drain_results();
        send_run(10);
        send_idle_pct = saved_pct;
        drain_results();
    endtask

    // Random PRNs and periods, some restarts, through all three idling phases.
    task automatic test_random_traffic();
        logic [15:0] period;
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            if (chunk == 1)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 24;
            end
            if (chunk == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_results();
            write_register(REG_PRN, 16'($urandom_range(65535)));
            case ($urandom_range(9))
                0: period = 16'($urandom_range(1022));
                1: period = 16'($urandom_range(1023, 65535));
                2: period = 16'd65535;
                default: period = 16'($urandom_range(1023, 1200));
            endcase
            write_register(REG_PERIOD, period);
            repeat (20) send_word($urandom_range(19) == 0);
        end
        drain_results();
    endtask

    initial
    begin
        restart_code();
        cfg_prn    = 6'd1;
        cfg_period = PERIOD_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_remainder_over_period();
        test_chip_wrap();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (5) @(posedge clk);
        $display("Sent %0d words, checked %0d samples, made %0d register writes.",
                 words_sent, samples_seen, writes_done);
        $display("Covered PRN clamping, short periods, chip wrap and mid-period changes.");
        if (err_count == 0)
            $display("[gps_ca_code_sampler] OK");
        else
            $display("[gps_ca_code_sampler] ERROR");
        $finish;
    end

endmodule
